### src/isl_pkg.sv
`timescale 1ns / 1ps

package isl_pkg;

   // List geometry.
   localparam int DEPTH      = 16;
   localparam int ELEM_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // Fixed field widths of the two channels.
   localparam int OP_W    = 3;
   localparam int POS_W   = 5;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int TOTAL_W = 5;

   // Width that holds a position or a count plus one without overflow.
   localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ADD_FRONT  = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD_REAR   = 3'd1;
   localparam logic [OP_W-1:0] OP_REM_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_REM_REAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_REM_AT     = 3'd4;
   localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd5;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
   localparam logic [STAT_W-1:0] ST_INDEX = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] new_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] removed_value;
      logic [STAT_W-1:0]         status;
      logic [TOTAL_W-1:0]        entry_total;
      logic                      list_empty;
   } rsp_payload_type;

   // Handshake between the sequencer and the top level.
   typedef struct packed {
      logic busy;
      logic done;
   } seq_status_type;

endpackage

### src/isl_ram.sv
`timescale 1ns / 1ps

module isl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/isl_seq.sv
`timescale 1ns / 1ps

module isl_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  isl_pkg::req_payload_type req,
   input  logic                     out_ready,
   output isl_pkg::seq_status_type  seq_status,
   output isl_pkg::rsp_payload_type result
);
   import isl_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TAKE_RD,
      S_TAKE_CAP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PUT,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      K_NONE,
      K_INSERT,
      K_REMOVE
   } kind_type;

   state_type             state_ff;
   logic                  insert_ff;
   logic [CNT_W-1:0]      cur_ff;
   logic [CNT_W-1:0]      slot_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [ELEM_WIDTH-1:0] val_ff;
   logic [ELEM_WIDTH-1:0] removed_ff;
   logic [STAT_W-1:0]     status_ff;

   kind_type          dec_kind;
   logic [CNT_W-1:0]  dec_slot;
   logic [STAT_W-1:0] dec_status;
   logic [CMP_W-1:0]  pos_x;
   logic [CMP_W-1:0]  cnt_x;

   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [ELEM_WIDTH-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [ELEM_WIDTH-1:0] ram_rd_data;
   logic [CNT_W-1:0]      cur_dn;
   logic [CNT_W-1:0]      cur_up;

   // Decide the operation's outcome from the current count.
   always_comb begin
      pos_x      = CMP_W'(req.position);
      cnt_x      = CMP_W'(count_ff);
      dec_kind   = K_NONE;
      dec_slot   = '0;
      dec_status = ST_OK;
      case (req.operation)
         OP_ADD_FRONT, OP_ADD_REAR: begin
            if (cnt_x >= CMP_W'(DEPTH)) begin
               dec_status = ST_FULL;
            end else begin
               dec_kind = K_INSERT;
               dec_slot = (req.operation == OP_ADD_FRONT) ? '0 : count_ff;
            end
         end
         OP_REM_FRONT, OP_REM_REAR: begin
            if (count_ff == '0) begin
               dec_status = ST_UNDER;
            end else begin
               dec_kind = K_REMOVE;
               dec_slot = (req.operation == OP_REM_FRONT) ? '0 : count_ff - 1'b1;
            end
         end
         OP_REM_AT: begin
            if (pos_x == '0 || pos_x > cnt_x) begin
               dec_status = ST_INDEX;
            end else begin
               dec_kind = K_REMOVE;
               dec_slot = CNT_W'(pos_x - 1'b1);
            end
         end
         OP_INS_BEFORE: begin
            if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
               dec_status = ST_INDEX;
            end else if (count_ff == '0) begin
               dec_status = ST_UNDER;
            end else if (cnt_x >= CMP_W'(DEPTH)) begin
               dec_status = ST_FULL;
            end else begin
               dec_kind = K_INSERT;
               dec_slot = CNT_W'(pos_x - 1'b1);
            end
         end
         default: begin
            dec_kind = K_NONE;
         end
      endcase
   end

   assign cur_dn = cur_ff - 1'b1;
   assign cur_up = cur_ff + 1'b1;

   // Memory port control: one read or one write per step.
   always_comb begin
      ram_wr_en   = (state_ff == S_SHIFT_WR) || (state_ff == S_PUT);
      ram_wr_addr = (state_ff == S_PUT) ? slot_ff[ADDR_W-1:0] : cur_ff[ADDR_W-1:0];
      ram_wr_data = (state_ff == S_PUT) ? val_ff : ram_rd_data;
      ram_rd_en   = (state_ff == S_TAKE_RD) || (state_ff == S_SHIFT_RD);
      if (state_ff == S_TAKE_RD) begin
         ram_rd_addr = slot_ff[ADDR_W-1:0];
      end else if (insert_ff) begin
         ram_rd_addr = cur_dn[ADDR_W-1:0];
      end else begin
         ram_rd_addr = cur_up[ADDR_W-1:0];
      end
   end

   isl_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer: take, shift entries one at a time, then place or report.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  slot_ff    <= dec_slot;
                  val_ff     <= ELEM_WIDTH'($unsigned(req.new_value));
                  removed_ff <= '0;
                  status_ff  <= dec_status;
                  case (dec_kind)
                     K_INSERT: begin
                        insert_ff <= 1'b1;
                        cur_ff    <= count_ff;
                        count_ff  <= count_ff + 1'b1;
                        state_ff  <= (count_ff > dec_slot) ? S_SHIFT_RD : S_PUT;
                     end
                     K_REMOVE: begin
                        insert_ff <= 1'b0;
                        cur_ff    <= dec_slot;
                        count_ff  <= count_ff - 1'b1;
                        state_ff  <= S_TAKE_RD;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_TAKE_RD: begin
               state_ff <= S_TAKE_CAP;
            end
            S_TAKE_CAP: begin
               removed_ff <= ram_rd_data;
               state_ff   <= (cur_ff < count_ff) ? S_SHIFT_RD : S_DONE;
            end
            S_SHIFT_RD: begin
               state_ff <= S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
               if (insert_ff) begin
                  cur_ff   <= cur_dn;
                  state_ff <= (cur_dn > slot_ff) ? S_SHIFT_RD : S_PUT;
               end else begin
                  cur_ff   <= cur_up;
                  state_ff <= (cur_up < count_ff) ? S_SHIFT_RD : S_DONE;
               end
            end
            S_PUT: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign seq_status.busy = (state_ff != S_IDLE);
   assign seq_status.done = (state_ff == S_DONE) && out_ready;

   assign result.removed_value = VALUE_W'(removed_ff);
   assign result.status        = status_ff;
   assign result.entry_total   = TOTAL_W'(count_ff);
   assign result.list_empty    = (count_ff == '0);

endmodule

### src/indexed_sequence_list.sv
`timescale 1ns / 1ps
// A failed or no-op beat goes to rsp_valid via the done state and the output register.
// Inserts move entries from the slot upward, then write; removals read, then shift down.
// Throughput: one beat at a time, bounded by the shift loop over the entry RAM, which
// reads and then writes each moved entry. A new beat may enter while a result waits.
// Reset clears the entry count and control state; the entry RAM is not cleared.
module indexed_sequence_list (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  isl_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output isl_pkg::rsp_payload_type rsp_payload
);
   import isl_pkg::*;

   seq_status_type  seq_status;
   rsp_payload_type seq_result;
   logic            out_ready;
   logic            req_accept;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = seq_status.busy;
   assign req_accept = req_valid && !req_stall;

   isl_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .req        (req_payload),
      .out_ready  (out_ready),
      .seq_status (seq_status),
      .result     (seq_result)
   );

   // Output register holds one finished beat until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_status.done) begin
         rsp_valid_ff   <= 1'b1;
         rsp_payload_ff <= seq_result;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The sequencer stays busy in the cycle after it takes a beat.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("sequencer not busy after accepting a beat");

   // A result is never produced onto an output that is still held.
   assert property (@(posedge clock) disable iff (reset)
      seq_status.done |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwrote a stalled beat");

   // Errors never report a removed value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != ST_OK) |-> (rsp_payload.removed_value == '0))
      else $error("failed operation returned a value");

   // Empty flag and count agree, and the count stays within the bound.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.list_empty == (rsp_payload.entry_total == '0))
                     && (rsp_payload.entry_total <= TOTAL_W'(DEPTH))))
      else $error("inconsistent entry count in result");

endmodule
